// ----- design/trp_pkg.sv -----
// ----------------------------------------------------------------------------
// trp_pkg
// Types and constants shared by the tagged record parser.
// ----------------------------------------------------------------------------
package trp_pkg;

  localparam int WORD_BYTES   = 4;
  localparam int BYTE_W       = 8;
  localparam int LEN_W        = 16;
  localparam int WORD_W       = WORD_BYTES * BYTE_W;
  localparam int SUB_W        = $clog2(WORD_BYTES);
  localparam int CFG_IDX_W    = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INT_TAG  = 1'b0,
    CFG_TEXT_TAG = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_TAG  = 3'd0,
    PH_INT  = 3'd1,
    PH_LEN  = 3'd2,
    PH_TEXT = 3'd3,
    PH_SKIP = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    EV_INT     = 3'd0,
    EV_HDR     = 3'd1,
    EV_TEXT    = 3'd2,
    EV_BADTYPE = 3'd3,
    EV_TRUNC   = 3'd4
  } event_t;

  localparam logic [BYTE_W-1:0] INT_TAG_RESET  = 8'd0;
  localparam logic [BYTE_W-1:0] TEXT_TAG_RESET = 8'd1;

endpackage

// ----- design/tagged_record_parser_top.sv -----
// ----------------------------------------------------------------------------
// tagged_record_parser_top
// Byte-serial parser for tag/length/value database records.
//
//   channel  dir  handshake             payload
//   in       in   in_valid / in_ready   data_byte, record_length
//   out      out  out_valid / out_ready event_res, int_value, text_length,
//                                       text_byte, last_text_byte, record_done
//   cfg      in   cfg_we                cfg_index, cfg_data
//
// One byte per cycle unless stalled; a result appears the cycle after its byte.
// All parse state updates in the accept cycle, results land in one output
// register, so in_ready drops only while that register holds an unread result.
// Every byte waits out such a stall, whether or not it yields a result.
// Reset is synchronous, no warm-up.
// ----------------------------------------------------------------------------
module tagged_record_parser_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [trp_pkg::BYTE_W-1:0]    data_byte,
  input  logic [trp_pkg::LEN_W-1:0]     record_length,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    event_res,
  output logic signed [trp_pkg::WORD_W-1:0] int_value,
  output logic [trp_pkg::LEN_W-1:0]     text_length,
  output logic [trp_pkg::BYTE_W-1:0]    text_byte,
  output logic                          last_text_byte,
  output logic                          record_done,
  input  logic                          cfg_we,
  input  logic [trp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [trp_pkg::BYTE_W-1:0]    cfg_data
);
  import trp_pkg::*;

  logic [BYTE_W-1:0] int_tag;
  logic [BYTE_W-1:0] text_tag;

  phase_t            parse_phase, parse_phase_next;
  logic [LEN_W-1:0]  byte_position, byte_position_next;
  logic [LEN_W-1:0]  held_length, held_length_next;
  logic [SUB_W-1:0]  sub_byte_count, sub_byte_count_next;
  logic [WORD_W-1:0] assembly_word, assembly_word_next;
  logic [LEN_W-1:0]  text_remaining, text_remaining_next;

  logic              accept;
  logic              at_start;
  phase_t            phase_cur;
  logic [LEN_W:0]    pos_after;
  logic              done;
  logic              tag_hit;
  logic              tag_overrun;
  logic [WORD_W-1:0] word_cur;
  logic              len_overrun;
  logic [LEN_W-1:0]  text_rem_dec;

  logic              res_valid;
  event_t            res_event;
  logic [WORD_W-1:0] res_int;
  logic [LEN_W-1:0]  res_len;
  logic [BYTE_W-1:0] res_byte;
  logic              res_last;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      int_tag  <= INT_TAG_RESET;
      text_tag <= TEXT_TAG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_INT_TAG:  int_tag  <= cfg_data;
        CFG_TEXT_TAG: text_tag <= cfg_data;
        default: ;
      endcase
    end
  end

  // current-byte view of state
  assign at_start  = (byte_position == '0);
  assign phase_cur = at_start ? PH_TAG : parse_phase;
  always_comb begin
    held_length_next = held_length;
    if (at_start) begin
      held_length_next = (record_length == '0) ? LEN_W'(1) : record_length;
    end
  end
  assign pos_after    = {1'b0, byte_position} + (LEN_W+1)'(1);
  assign done         = pos_after >= {1'b0, held_length_next};
  assign tag_hit      = (data_byte == int_tag) || (data_byte == text_tag);
  assign tag_overrun  = ({1'b0, pos_after} + (LEN_W+2)'(WORD_BYTES))
                        > {2'b00, held_length_next};
  assign word_cur     = assembly_word
                        | (WORD_W'(data_byte) << {sub_byte_count, 3'b000});
  assign len_overrun  = ({{(WORD_W-LEN_W){1'b0}}, pos_after} + {1'b0, word_cur})
                        > {{(WORD_W-LEN_W+1){1'b0}}, held_length_next};
  assign text_rem_dec = (text_remaining != '0) ? text_remaining - LEN_W'(1)
                                               : text_remaining;

  // next state
  always_comb begin
    parse_phase_next    = phase_cur;
    sub_byte_count_next = sub_byte_count;
    assembly_word_next  = assembly_word;
    text_remaining_next = text_remaining;
    unique case (phase_cur)
      PH_TAG: begin
        sub_byte_count_next = '0;
        assembly_word_next  = '0;
        if (!tag_hit || tag_overrun) begin
          parse_phase_next = PH_SKIP;
        end else if (data_byte == int_tag) begin
          parse_phase_next = PH_INT;
        end else begin
          parse_phase_next = PH_LEN;
        end
      end
      PH_INT, PH_LEN: begin
        assembly_word_next = word_cur;
        if (sub_byte_count == SUB_W'(WORD_BYTES - 1)) begin
          sub_byte_count_next = '0;
          if (phase_cur == PH_INT) begin
            parse_phase_next = PH_TAG;
          end else if (len_overrun) begin
            parse_phase_next = PH_SKIP;
          end else begin
            text_remaining_next = word_cur[LEN_W-1:0];
            parse_phase_next    = (word_cur[LEN_W-1:0] == '0) ? PH_TAG : PH_TEXT;
          end
        end else begin
          sub_byte_count_next = sub_byte_count + SUB_W'(1);
        end
      end
      PH_TEXT: begin
        text_remaining_next = text_rem_dec;
        if (text_rem_dec == '0) begin
          parse_phase_next = PH_TAG;
        end
      end
      default: parse_phase_next = PH_SKIP;
    endcase
    if (done) begin
      parse_phase_next    = PH_TAG;
      sub_byte_count_next = '0;
      byte_position_next  = '0;
    end else begin
      byte_position_next  = pos_after[LEN_W-1:0];
    end
  end

  // result of this byte
  always_comb begin
    res_valid = 1'b0;
    res_event = EV_INT;
    res_int   = '0;
    res_len   = '0;
    res_byte  = '0;
    res_last  = 1'b0;
    unique case (phase_cur)
      PH_TAG: begin
        if (!tag_hit) begin
          res_valid = 1'b1;
          res_event = EV_BADTYPE;
        end else if (tag_overrun) begin
          res_valid = 1'b1;
          res_event = EV_TRUNC;
        end
      end
      PH_INT, PH_LEN: begin
        if (sub_byte_count == SUB_W'(WORD_BYTES - 1)) begin
          res_valid = 1'b1;
          if (phase_cur == PH_INT) begin
            res_event = EV_INT;
            res_int   = word_cur;
          end else if (len_overrun) begin
            res_event = EV_TRUNC;
          end else begin
            res_event = EV_HDR;
            res_len   = word_cur[LEN_W-1:0];
          end
        end
      end
      PH_TEXT: begin
        res_valid = 1'b1;
        res_event = EV_TEXT;
        res_byte  = data_byte;
        res_last  = (text_rem_dec == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= PH_TAG;
      byte_position  <= '0;
      held_length    <= '0;
      sub_byte_count <= '0;
      assembly_word  <= '0;
      text_remaining <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        parse_phase    <= parse_phase_next;
        byte_position  <= byte_position_next;
        held_length    <= held_length_next;
        sub_byte_count <= sub_byte_count_next;
        assembly_word  <= assembly_word_next;
        text_remaining <= text_remaining_next;
        out_valid      <= res_valid;
      end else if (out_ready) begin
        out_valid      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      event_res      <= res_event;
      int_value      <= res_int;
      text_length    <= res_len;
      text_byte      <= res_byte;
      last_text_byte <= res_last;
      record_done    <= done;
    end
  end

`ifndef SYNTH
  a_text_nonzero: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_TEXT |-> text_remaining != '0)
    else $error("text phase with no bytes left");

  a_pos_in_record: assert property (@(posedge clk) disable iff (rst)
    byte_position != '0 |-> byte_position < held_length)
    else $error("byte position past record end");

  a_sub_in_word: assert property (@(posedge clk) disable iff (rst)
    sub_byte_count != '0 |-> (parse_phase == PH_INT || parse_phase == PH_LEN))
    else $error("word byte count outside word phase");

  a_last_only_text: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != EV_TEXT |-> !last_text_byte)
    else $error("last text flag on non-text transaction");
`endif

endmodule

// ----- verif/tb_tagged_record_parser_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tagged_record_parser_top
// Self-checking bench for the byte-serial tagged record parser.
//
// A directed table covers the edge cases: bad tag, overrun on a tag and on a
// full 32-bit text length, empty text, the largest integer and a zero record
// length. Random well-formed records with random content follow, mixed with
// broken records and noise, under several tag settings. Each result
// transaction is checked per field against fixed rows or an in-bench model.
// ----------------------------------------------------------------------------
module tb_tagged_record_parser_top;
  import trp_pkg::*;

  typedef struct packed {
    event_t                   ev;
    logic signed [WORD_W-1:0] ival;
    logic [LEN_W-1:0]         tlen;
    logic [BYTE_W-1:0]        tbyte;
    logic                     last;
    logic                     done;
  } parse_event_t;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_FIXED
  } check_t;

  typedef struct {
    logic [BYTE_W-1:0] b;
    logic [LEN_W-1:0]  rlen;
    check_t            chk;
    parse_event_t      fixed;
  } table_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     data_byte = '0;
  logic [LEN_W-1:0]      record_length = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [2:0]            event_res;
  logic signed [WORD_W-1:0] int_value;
  logic [LEN_W-1:0]      text_length;
  logic [BYTE_W-1:0]     text_byte;
  logic                  last_text_byte;
  logic                  record_done;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_INT_TAG;
  logic [BYTE_W-1:0]     cfg_data = '0;

  // payload side info for the byte currently offered
  check_t                row_check = CHK_MODEL;
  parse_event_t          row_fixed = '0;

  // parser model state
  logic [BYTE_W-1:0]     tag_int = INT_TAG_RESET;
  logic [BYTE_W-1:0]     tag_text = TEXT_TAG_RESET;
  phase_t                m_phase = PH_TAG;
  logic [LEN_W-1:0]      m_pos = '0;
  logic [LEN_W-1:0]      m_len = '0;
  logic [SUB_W-1:0]      m_sub = '0;
  logic [WORD_W-1:0]     m_word = '0;
  logic [LEN_W-1:0]      m_rem = '0;

  parse_event_t          pending_events[$];
  table_row_t            rows[$];
  int                    mismatch_count = 0;
  int                    events_checked = 0;
  int                    bytes_sent = 0;
  int                    tag_settings = 1;
  bit                    steady = 1'b0;
  logic [BYTE_W-1:0]     cur_int_tag = INT_TAG_RESET;
  logic [BYTE_W-1:0]     cur_text_tag = TEXT_TAG_RESET;

  tagged_record_parser_top DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .record_length  (record_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_res      (event_res),
    .int_value      (int_value),
    .text_length    (text_length),
    .text_byte      (text_byte),
    .last_text_byte (last_text_byte),
    .record_done    (record_done),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 21);
  end

  function automatic parse_event_t mk_event(input event_t ev, input logic [WORD_W-1:0] ival,
                                            input logic [LEN_W-1:0] tlen,
                                            input logic [BYTE_W-1:0] tbyte,
                                            input logic last, input logic done);
    parse_event_t r;
    r.ev    = ev;
    r.ival  = ival;
    r.tlen  = tlen;
    r.tbyte = tbyte;
    r.last  = last;
    r.done  = done;
    return r;
  endfunction

  function automatic void add_row(input logic [BYTE_W-1:0] b, input logic [LEN_W-1:0] rlen,
                                  input check_t chk, input parse_event_t fixed);
    table_row_t row;
    row.b     = b;
    row.rlen  = rlen;
    row.chk   = chk;
    row.fixed = fixed;
    rows.insert(rows.size(), row);
  endfunction

  // Advances the model by one byte; returns 1 when the byte yields a result.
  function automatic bit parse_byte(input logic [BYTE_W-1:0] b, input logic [LEN_W-1:0] rlen,
                                    output parse_event_t r);
    longint pos_next;
    bit     fin;
    bit     hit;
    r   = mk_event(EV_INT, '0, '0, '0, 1'b0, 1'b0);
    hit = 1'b0;
    if (m_pos == 0) begin
      m_len   = (rlen == 0) ? 16'd1 : rlen;
      m_phase = PH_TAG;
    end
    pos_next = longint'(m_pos) + 1;
    fin      = pos_next >= longint'(m_len);
    r.done   = fin;
    case (m_phase)
      PH_TAG: begin
        m_sub  = '0;
        m_word = '0;
        if (b == tag_int || b == tag_text) begin
          if (pos_next + WORD_BYTES > longint'(m_len)) begin
            r.ev    = EV_TRUNC;
            hit     = 1'b1;
            m_phase = PH_SKIP;
          end else begin
            m_phase = (b == tag_int) ? PH_INT : PH_LEN;
          end
        end else begin
          r.ev    = EV_BADTYPE;
          hit     = 1'b1;
          m_phase = PH_SKIP;
        end
      end
      PH_INT, PH_LEN: begin
        m_word = m_word | ({24'd0, b} << {m_sub, 3'b000});
        if (m_sub == 2'd3) begin
          m_sub = '0;
          if (m_phase == PH_INT) begin
            r.ev    = EV_INT;
            r.ival  = m_word;
            hit     = 1'b1;
            m_phase = PH_TAG;
          end else if (pos_next + longint'(m_word) > longint'(m_len)) begin
            r.ev    = EV_TRUNC;
            hit     = 1'b1;
            m_phase = PH_SKIP;
          end else begin
            m_rem   = m_word[LEN_W-1:0];
            r.ev    = EV_HDR;
            r.tlen  = m_rem;
            hit     = 1'b1;
            m_phase = (m_rem == 0) ? PH_TAG : PH_TEXT;
          end
        end else begin
          m_sub = m_sub + 1'b1;
        end
      end
      PH_TEXT: begin
        if (m_rem > 0) m_rem = m_rem - 1'b1;
        r.ev    = EV_TEXT;
        r.tbyte = b;
        r.last  = (m_rem == 0);
        hit     = 1'b1;
        if (m_rem == 0) m_phase = PH_TAG;
      end
      default: m_phase = PH_SKIP;
    endcase
    if (fin) begin
      m_pos   = '0;
      m_phase = PH_TAG;
      m_sub   = '0;
    end else begin
      m_pos = pos_next[LEN_W-1:0];
    end
    return hit;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d (result %0d)",
             $realtime, what, got, want, events_checked);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : monitor
    parse_event_t pred;
    parse_event_t want;
    bit           hit;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INT_TAG:  tag_int = cfg_data;
          CFG_TEXT_TAG: tag_text = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        hit = parse_byte(data_byte, record_length, pred);
        case (row_check)
          CHK_MODEL: if (hit) pending_events.insert(pending_events.size(), pred);
          CHK_FIXED: pending_events.insert(pending_events.size(), row_fixed);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          report_mismatch("unexpected result", event_res, -1);
        end else begin
          want = pending_events.pop_front();
          if (event_res !== want.ev) report_mismatch("event_res", event_res, want.ev);
          if (int_value !== want.ival) report_mismatch("int_value", int_value, want.ival);
          if (text_length !== want.tlen) report_mismatch("text_length", text_length, want.tlen);
          if (text_byte !== want.tbyte) report_mismatch("text_byte", text_byte, want.tbyte);
          if (last_text_byte !== want.last)
            report_mismatch("last_text_byte", last_text_byte, want.last);
          if (record_done !== want.done)
            report_mismatch("record_done", record_done, want.done);
          events_checked++;
        end
      end
    end
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic [LEN_W-1:0] rlen,
                           input check_t chk, input parse_event_t fixed);
    while (!steady && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    record_length <= rlen;
    row_check     <= chk;
    row_fixed     <= fixed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Sender stops until every expected result transaction has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tags(input logic [BYTE_W-1:0] int_tag, input logic [BYTE_W-1:0] text_tag);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INT_TAG;
    cfg_data  <= int_tag;
    @(posedge clk);
    cfg_index <= CFG_TEXT_TAG;
    cfg_data  <= text_tag;
    @(posedge clk);
    cfg_we       <= 1'b0;
    cur_int_tag  = int_tag;
    cur_text_tag = text_tag;
    tag_settings++;
  endtask

  task automatic send_record();
    logic [BYTE_W-1:0] rec[$];
    logic [WORD_W-1:0] word;
    int                nfields;
    int                pick;
    int                tlen;
    int                declared;
    nfields = $urandom_range(1, 4);
    for (int f = 0; f < nfields; f++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        word = $urandom;
        rec.insert(rec.size(), cur_int_tag);
        for (int k = 0; k < WORD_BYTES; k++) rec.insert(rec.size(), word[8*k +: 8]);
      end else if (pick < 90) begin
        tlen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        word = ($urandom_range(0, 19) == 0) ? $urandom : tlen;
        rec.insert(rec.size(), cur_text_tag);
        for (int k = 0; k < WORD_BYTES; k++) rec.insert(rec.size(), word[8*k +: 8]);
        if (word == tlen) begin
          for (int k = 0; k < tlen; k++)
            rec.insert(rec.size(), BYTE_W'($urandom_range(0, 255)));
        end
      end else begin
        rec.insert(rec.size(), BYTE_W'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 4)) rec.insert(rec.size(), BYTE_W'($urandom_range(0, 255)));
      end
    end
    declared = rec.size();
    pick = $urandom_range(0, 99);
    if (pick < 10) declared = $urandom_range(1, rec.size());
    else if (pick < 18) declared = declared + $urandom_range(1, 6);
    for (int i = 0; i < rec.size(); i++) begin
      push_byte(rec[i], (i == 0) ? declared[LEN_W-1:0] : LEN_W'($urandom_range(0, 65535)),
                CHK_MODEL, '0);
    end
  endtask

  initial begin : stimulus
    parse_event_t none;
    logic [BYTE_W-1:0] ta;
    int           start;
    none = mk_event(EV_INT, '0, '0, '0, 1'b0, 1'b0);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // bad tag, zero length read as one
    add_row(8'h05, 16'd0, CHK_FIXED, mk_event(EV_BADTYPE, 0, 0, 0, 0, 1));
    // int tag with no room; rest of record ignored, no record_done on its end
    add_row(8'h00, 16'd3, CHK_FIXED, mk_event(EV_TRUNC, 0, 0, 0, 0, 0));
    add_row(8'hFF, 16'hFFFF, CHK_NONE, none);
    add_row(8'h00, 16'h0000, CHK_NONE, none);
    // largest integer
    add_row(8'h00, 16'd5, CHK_NONE, none);
    add_row(8'hFF, 16'hFFFF, CHK_NONE, none);
    add_row(8'hFF, 16'h0000, CHK_NONE, none);
    add_row(8'hFF, 16'hAAAA, CHK_NONE, none);
    add_row(8'h7F, 16'h5555, CHK_FIXED, mk_event(EV_INT, 32'h7FFF_FFFF, 0, 0, 0, 1));
    // two text bytes
    add_row(8'h01, 16'd7, CHK_NONE, none);
    add_row(8'h02, 16'h0000, CHK_NONE, none);
    add_row(8'h00, 16'hFFFF, CHK_NONE, none);
    add_row(8'h00, 16'h0000, CHK_NONE, none);
    add_row(8'h00, 16'h1234, CHK_FIXED, mk_event(EV_HDR, 0, 2, 0, 0, 0));
    add_row(8'h41, 16'h0000, CHK_MODEL, none);
    add_row(8'hFF, 16'hFFFF, CHK_MODEL, none);
    // empty text, then a length that overruns only in the upper 16 bits
    add_row(8'h01, 16'd10, CHK_NONE, none);
    add_row(8'h00, 16'h0000, CHK_NONE, none);
    add_row(8'h00, 16'h0000, CHK_NONE, none);
    add_row(8'h00, 16'h0000, CHK_NONE, none);
    add_row(8'h00, 16'h0000, CHK_FIXED, mk_event(EV_HDR, 0, 0, 0, 0, 0));
    add_row(8'h01, 16'h0000, CHK_NONE, none);
    add_row(8'h00, 16'h0000, CHK_NONE, none);
    add_row(8'h00, 16'h0000, CHK_NONE, none);
    add_row(8'h01, 16'h0000, CHK_NONE, none);
    add_row(8'h00, 16'h0000, CHK_FIXED, mk_event(EV_TRUNC, 0, 0, 0, 0, 1));
    foreach (rows[i]) push_byte(rows[i].b, rows[i].rlen, rows[i].chk, rows[i].fixed);
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        1: write_tags(8'hFF, 8'h00);
        2: begin
          ta = BYTE_W'($urandom_range(0, 255));
          write_tags(ta, ta);
          steady = 1'b1;
        end
        3: begin
          steady = 1'b0;
          ta = BYTE_W'($urandom_range(0, 255));
          write_tags(ta, ta ^ BYTE_W'($urandom_range(1, 255)));
        end
        4: write_tags(8'h00, 8'hFF);
        default: ;
      endcase
      start = bytes_sent;
      while (bytes_sent - start < 80) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 6))
            push_byte(BYTE_W'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 65535)),
                      CHK_MODEL, '0);
        end else begin
          send_record();
        end
      end
    end

    drain();
    if (pending_events.size() != 0)
      report_mismatch("results never produced", 0, pending_events.size());
    $display("Covered %0d input bytes and %0d checked results under %0d tag settings,",
             bytes_sent, events_checked, tag_settings);
    $display("including bad tags, overruns, empty text, shared tags and length mismatches.");
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- tagged_record_parser_top.f -----
design/trp_pkg.sv
design/tagged_record_parser_top.sv
verif/tb_tagged_record_parser_top.sv
